// ===== rtl/imadec_pkg.sv =====
// Shared types, widths and tables for the IMA ADPCM block decoder.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package imadec_pkg;

  localparam int WORD_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int SLOT_W     = 13;
  localparam int CFG_W      = 2;
  localparam int IDX_W      = 7;
  localparam int STEP_W     = 15;
  localparam int CODE_W     = 4;

  localparam logic [IDX_W-1:0] MAX_STEP_INDEX = 7'd88;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]           step_index_t;
  typedef logic [STEP_W-1:0]          step_t;
  typedef logic [CODE_W-1:0]          code_t;

  // Quantizer step size for a step index; indexes past the end read the top entry.
  function automatic step_t step_size(input step_index_t idx);
    step_t s;
    unique case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Signed step index adjustment for the magnitude bits of a code.
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    unique case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/imadec_if.sv =====
// Valid/ready channel interfaces for the IMA ADPCM block decoder.
// Depends on imadec_pkg for field widths.
`default_nettype none

// Compressed word channel.
interface imadec_word_if;
  logic                             valid;
  logic                             ready;
  logic [imadec_pkg::WORD_W-1:0]    data_word;
  logic                             block_start;

  modport source (output valid, output data_word, output block_start, input ready);
  modport sink   (input valid, input data_word, input block_start, output ready);
endinterface

// Decoded sample channel.
interface imadec_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [imadec_pkg::SAMPLE_W-1:0] sample;
  logic                             channel;
  logic [imadec_pkg::SLOT_W-1:0]    slot;
  logic                             last;

  modport source (output valid, output sample, output channel, output slot, output last,
                  input ready);
  modport sink   (input valid, input sample, input channel, input slot, input last,
                  output ready);
endinterface

// Configuration write channel for the channel count register.
interface imadec_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [imadec_pkg::CFG_W-1:0]     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ima_adpcm_block_decoder_top.sv =====
// IMA ADPCM block decoder, top level.
// Depends on imadec_pkg and the channel interfaces in imadec_if.sv.
`default_nettype none

// Usage:
// - words: one 32-bit word of a compressed block per item, with block_start set on the
//   first word of a block. The first word per channel is a preamble (predictor in bits
//   15..0, step index in bits 23..16); later words carry eight 4-bit codes, channels
//   taken in turn.
// - samples: one decoded sample per item with its channel, slot in the block, and last
//   set on the final sample of each input word.
// - cfg: writes the channel count (1 or 2); write only while the block is idle.
// Each word is held in the word register and each sample in the output register.
// Throughput: one code per cycle while the output register is not stalled, through a
// single step-table lookup, add and saturate; the word register is refilled in the
// same cycle that its last sample is produced.
// Reset: both predictors and step indices clear, the block expects a preamble for
// channel 0, and the channel count returns to 1.
// Stall: while a sample waits in the output register the decode step holds; a new
// word is still taken if the word register is free.
module ima_adpcm_block_decoder_top #(
  parameter int MAX_CHANNELS          = 2,
  parameter int MAX_SAMPLES_PER_BLOCK = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  imadec_word_if.sink       words,
  imadec_sample_if.source   samples,
  imadec_cfg_if.sink        cfg
);

  localparam int GROUPS   = MAX_SAMPLES_PER_BLOCK / 8;
  localparam int GW       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SW       = imadec_pkg::SLOT_W;
  localparam logic [GW-1:0] GROUP_LIMIT = GW'(GROUPS - 1);

  // Configuration register.
  logic [imadec_pkg::CFG_W-1:0] channel_count;

  // Decoder state.
  imadec_pkg::sample_t      predictors   [2];
  imadec_pkg::step_index_t  step_indices [2];
  logic                     in_preamble;
  logic                     current_channel;
  logic [GW-1:0]            group_count;

  // Word register and code counter.
  logic                     in_full;
  logic [imadec_pkg::WORD_W-1:0] in_word;
  logic                     in_bs;
  logic [2:0]               code_cnt;

  // Output register.
  logic                     out_valid;
  imadec_pkg::sample_t      out_sample;
  logic                     out_channel;
  logic [SW-1:0]            out_slot;
  logic                     out_last;

  // Decode step signals.
  logic                     two_ch;
  logic                     pre_eff;
  logic                     ch;
  logic                     go;
  logic                     finish;
  imadec_pkg::code_t        code;
  imadec_pkg::step_t        step;
  logic [15:0]              diff;
  logic signed [17:0]       pred_wide;
  imadec_pkg::sample_t      pred_next;
  logic signed [8:0]        idx_wide;
  imadec_pkg::step_index_t  idx_next;
  imadec_pkg::step_index_t  pre_idx;
  logic [SW-1:0]            slot_code;
  logic [SW-1:0]            g13;
  logic                     last_ch;

  assign cfg.ready = 1'b1;

  // Channel count in use: 0 acts as 1, 3 as 2, and never above MAX_CHANNELS.
  assign two_ch  = (channel_count >= 2'd2) && (MAX_CHANNELS >= 2);
  assign pre_eff = in_bs | in_preamble;
  assign ch      = in_bs ? 1'b0 : (current_channel & two_ch);
  assign last_ch = !two_ch || ch;

  assign go     = in_full && (!out_valid || samples.ready);
  assign finish = go && (pre_eff || (code_cnt == 3'd7));
  assign words.ready = !in_full || finish;

  // One code: difference from the step size, then saturate the predictor.
  always_comb begin
    code = in_word[{code_cnt, 2'b00} +: 4];
    step = imadec_pkg::step_size(step_indices[ch]);
    diff = 16'(step >> 3);
    if (code[0]) diff = diff + 16'(step >> 2);
    if (code[1]) diff = diff + 16'(step >> 1);
    if (code[2]) diff = diff + 16'(step);
    if (code[3]) pred_wide = 18'(predictors[ch]) - $signed({2'b00, diff});
    else         pred_wide = 18'(predictors[ch]) + $signed({2'b00, diff});
    if (pred_wide > 18'sd32767)        pred_next = 16'sh7fff;
    else if (pred_wide < -18'sd32768)  pred_next = -16'sh8000;
    else                               pred_next = pred_wide[15:0];
    idx_wide = $signed({2'b00, step_indices[ch]}) + 9'(imadec_pkg::index_adjust(code[2:0]));
    if (idx_wide < 9'sd0)                                     idx_next = '0;
    else if (idx_wide > $signed({2'b00, imadec_pkg::MAX_STEP_INDEX}))
      idx_next = imadec_pkg::MAX_STEP_INDEX;
    else                                                      idx_next = idx_wide[6:0];
  end

  // Preamble step index, clamped to the table.
  assign pre_idx = (in_word[23:16] > {1'b0, imadec_pkg::MAX_STEP_INDEX}) ?
                   imadec_pkg::MAX_STEP_INDEX : in_word[22:16];

  // Slot of this code: n + 8*n*group + channel + n*code.
  assign g13 = SW'(group_count);
  always_comb begin
    if (two_ch) slot_code = SW'(2) + SW'(ch) + (g13 << 4) + SW'({code_cnt, 1'b0});
    else        slot_code = SW'(1) + (g13 << 3) + SW'(code_cnt);
  end

  // Configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 2'd1;
    end else if (cfg.valid) begin
      channel_count <= cfg.data;
    end
  end

  // Word register and code counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      code_cnt <= '0;
    end else begin
      if (words.valid && words.ready) begin
        in_full <= 1'b1;
      end else if (finish) begin
        in_full <= 1'b0;
      end
      if (finish) code_cnt <= '0;
      else if (go) code_cnt <= code_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      in_word <= words.data_word;
      in_bs   <= words.block_start;
    end
  end

  // Decoder state update, one code or one preamble per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      predictors[0]   <= '0;
      predictors[1]   <= '0;
      step_indices[0] <= '0;
      step_indices[1] <= '0;
      in_preamble     <= 1'b1;
      current_channel <= 1'b0;
      group_count     <= '0;
    end else if (go) begin
      if (pre_eff) begin
        predictors[ch]   <= in_word[15:0];
        step_indices[ch] <= pre_idx;
        if (last_ch) begin
          in_preamble     <= 1'b0;
          current_channel <= 1'b0;
          group_count     <= '0;
        end else begin
          in_preamble     <= 1'b1;
          current_channel <= 1'b1;
        end
      end else begin
        predictors[ch]   <= pred_next;
        step_indices[ch] <= idx_next;
        if (code_cnt == 3'd7) begin
          if (last_ch) begin
            current_channel <= 1'b0;
            if (group_count < GROUP_LIMIT) group_count <= group_count + GW'(1);
          end else begin
            current_channel <= 1'b1;
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (samples.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_channel <= ch;
      if (pre_eff) begin
        out_sample <= in_word[15:0];
        out_slot   <= SW'(ch);
        out_last   <= 1'b1;
      end else begin
        out_sample <= pred_next;
        out_slot   <= slot_code;
        out_last   <= (code_cnt == 3'd7);
      end
    end
  end

  assign samples.valid   = out_valid;
  assign samples.sample  = out_sample;
  assign samples.channel = out_channel;
  assign samples.slot    = out_slot;
  assign samples.last    = out_last;

  // The code counter only runs while a word is held.
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> code_cnt == 3'd0)
    else $error("code counter nonzero with no word held");

  // Stored step indices stay inside the table.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    step_indices[0] <= imadec_pkg::MAX_STEP_INDEX && step_indices[1] <= imadec_pkg::MAX_STEP_INDEX)
    else $error("step index out of range");

  // A word's final step frees the word register unless a new word is taken.
  a_finish_frees: assert property (@(posedge clk) disable iff (rst)
    (finish && !(words.valid && words.ready)) |=> !in_full)
    else $error("word register still full after final step");

  // No sample is offered right after reset.
  a_reset_out: assert property (@(posedge clk) rst |=> !samples.valid)
    else $error("sample offered after reset");

endmodule

`default_nettype wire
